>>> src/s2w_pkg.sv
package s2w_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int VP_W       = 13;
    localparam int PIX_W      = 12;
    localparam int DEPTH_W    = 16;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 96;
    localparam int INV_W      = 32;
    localparam int INV_N      = 16;
    localparam int QUEUE_D    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_VP_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VP_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3      = 3'd5;

    typedef logic [3:0][CFG_DATA_W-1:0] t_rows;
    typedef logic signed [INV_W-1:0] t_inv [INV_N];

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [PIX_W-1:0]   cursor_y;
        logic [PIX_W-1:0]   cursor_x;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_head;

    // truncated quotient magnitude to signed 32 bits with saturation
    function automatic logic signed [31:0] sat32(input logic neg, input logic ovf,
                                                 input logic [31:0] q);
        logic [31:0] m;
        begin
            if (neg) begin
                m = (ovf || q > 32'h8000_0000) ? 32'h8000_0000 : q;
                sat32 = $signed(32'd0 - m);
            end else begin
                sat32 = (ovf || q[31]) ? 32'sh7FFF_FFFF : $signed(q);
            end
        end
    endfunction

endpackage

>>> src/s2w_inv.sv
module s2w_inv import s2w_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_restart,
    input  t_rows i_rows,
    output t_inv  o_inv,
    output logic  o_valid
);

    typedef enum logic [2:0] {S_IDLE, S_COF_A, S_COF_B, S_DET, S_DIV_LD, S_DIV_RUN} t_state;

    t_state r_state;
    logic [3:0] r_k;
    logic [4:0] r_cnt;
    logic signed [15:0] r_m0 [3];
    logic signed [32:0] r_mn [3];
    logic signed [43:0] r_cof [INV_N];
    logic signed [61:0] r_det;
    logic [61:0] r_rem;
    logic [31:0] r_nq;
    logic r_ovf;
    logic r_neg;
    logic r_valid;
    t_inv r_inv;

    function automatic logic signed [15:0] elem(input t_rows rows, input logic [1:0] r,
                                                input logic [1:0] c);
        elem = $signed(rows[r][16*c +: 16]);
    endfunction

    function automatic logic [1:0] skip(input logic [1:0] n, input logic [1:0] x);
        skip = (n < x) ? n : 2'(n + 2'd1);
    endfunction

    logic signed [15:0] w_m [3][3];
    logic signed [32:0] w_mn [3];
    logic signed [50:0] w_det3;
    logic [50:0] w_mag;
    logic [42:0] w_cmag;
    logic signed [43:0] w_cq;
    logic [3:0] w_raddr;
    logic signed [43:0] w_cof;
    logic [43:0] w_cmg;
    logic [61:0] w_dmg;
    logic [62:0] w_t;
    logic w_ge;
    logic [61:0] w_rem_n;
    logic [31:0] w_nq_n;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                w_m[a][b] = elem(i_rows, skip(2'(a), r_k[3:2]), skip(2'(b), r_k[1:0]));
            end
        end
        w_mn[0] = w_m[1][1] * w_m[2][2] - w_m[1][2] * w_m[2][1];
        w_mn[1] = w_m[1][0] * w_m[2][2] - w_m[1][2] * w_m[2][0];
        w_mn[2] = w_m[1][0] * w_m[2][1] - w_m[1][1] * w_m[2][0];
        w_det3 = r_m0[0] * r_mn[0] - r_m0[1] * r_mn[1] + r_m0[2] * r_mn[2];
        if (r_k[2] ^ r_k[0]) begin
            w_det3 = -w_det3;
        end
        w_mag  = w_det3[50] ? 51'(-w_det3) : 51'(w_det3);
        w_cmag = 43'(w_mag >> 8);
        w_cq   = w_det3[50] ? -$signed({1'b0, w_cmag}) : $signed({1'b0, w_cmag});
        w_raddr = (r_state == S_DET) ? {2'b00, r_k[1:0]} : {r_k[1:0], r_k[3:2]};
        w_cof  = r_cof[w_raddr];
        w_cmg  = w_cof[43] ? 44'(-w_cof) : 44'(w_cof);
        w_dmg  = r_det[61] ? 62'(-r_det) : 62'(r_det);
        w_t    = {r_rem, r_nq[31]};
        w_ge   = w_t >= {1'b0, w_dmg};
        w_rem_n = w_ge ? 62'(w_t - {1'b0, w_dmg}) : w_t[61:0];
        w_nq_n = {r_nq[30:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COF_A;
            r_k     <= '0;
            r_valid <= 1'b0;
        end else if (i_restart) begin
            r_state <= S_COF_A;
            r_k     <= '0;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                end
                S_COF_A: begin
                    for (int b = 0; b < 3; b++) begin
                        r_m0[b] <= w_m[0][b];
                        r_mn[b] <= w_mn[b];
                    end
                    r_state <= S_COF_B;
                end
                S_COF_B: begin
                    r_cof[r_k] <= w_cq;
                    r_k <= r_k + 4'd1;
                    if (r_k == 4'd15) begin
                        r_det   <= '0;
                        r_state <= S_DET;
                    end else begin
                        r_state <= S_COF_A;
                    end
                end
                S_DET: begin
                    r_det <= r_det + elem(i_rows, 2'd0, r_k[1:0]) * w_cof;
                    if (r_k == 4'd3) begin
                        r_k     <= '0;
                        r_state <= S_DIV_LD;
                    end else begin
                        r_k <= r_k + 4'd1;
                    end
                end
                S_DIV_LD: begin
                    if (r_det == '0) begin
                        r_inv[r_k] <= '0;
                        r_k <= r_k + 4'd1;
                        if (r_k == 4'd15) begin
                            r_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_rem   <= 62'(w_cmg >> 8);
                        r_nq    <= {w_cmg[7:0], 24'b0};
                        r_ovf   <= 62'(w_cmg >> 8) >= w_dmg;
                        r_neg   <= w_cof[43] ^ r_det[61];
                        r_cnt   <= 5'd31;
                        r_state <= S_DIV_RUN;
                    end
                end
                S_DIV_RUN: begin
                    r_rem <= w_rem_n;
                    r_nq  <= w_nq_n;
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd0) begin
                        r_inv[r_k] <= sat32(r_neg, r_ovf, w_nq_n);
                        r_k <= r_k + 4'd1;
                        if (r_k == 4'd15) begin
                            r_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_DIV_LD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_inv   = r_inv;
    assign o_valid = r_valid;

endmodule

>>> src/s2w_front.sv
module s2w_front import s2w_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_inv_valid,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [IN_DATA_W-1:0] i_s_axis_tdata,
    input  logic                 i_pop,
    output t_q_head              o_head
);

    t_item      r_q [QUEUE_D];
    logic [1:0] r_wp;
    logic [1:0] r_rp;
    logic [2:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_s_axis_tready = i_inv_valid && (r_cnt != 3'(QUEUE_D));
    assign w_push = i_s_axis_tvalid && o_s_axis_tready;
    assign w_pop  = i_pop && (r_cnt != 3'd0);
    assign o_head.valid = r_cnt != 3'd0;
    assign o_head.item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= i_s_axis_tdata;
                r_wp <= r_wp + 2'd1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + 3'(w_push) - 3'(w_pop);
        end
    end

endmodule

>>> src/s2w_back.sv
module s2w_back import s2w_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_q_head               i_head,
    output logic                  o_pop,
    input  logic [VP_W-1:0]       i_vp_w,
    input  logic [VP_W-1:0]       i_vp_h,
    input  t_inv                  i_inv,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic [0:0]            o_m_axis_tuser
);

    localparam int ND_STEPS = 29;
    localparam int HD_STEPS = 32;

    typedef struct packed {
        logic [12:0] rem;
        logic [28:0] nq;
    } t_nd;

    typedef struct packed {
        logic [65:0] rem;
        logic [31:0] nq;
    } t_hd;

    function automatic t_nd nd_step(input t_nd s, input logic [12:0] dvs);
        logic [13:0] t;
        logic ge;
        begin
            t = {s.rem, s.nq[28]};
            ge = t >= {1'b0, dvs};
            nd_step.rem = ge ? 13'(t - {1'b0, dvs}) : t[12:0];
            nd_step.nq  = {s.nq[27:0], ge};
        end
    endfunction

    function automatic t_hd hd_step(input t_hd s, input logic [65:0] dvs);
        logic [66:0] t;
        logic ge;
        begin
            t = {s.rem, s.nq[31]};
            ge = t >= {1'b0, dvs};
            hd_step.rem = ge ? 66'(t - {1'b0, dvs}) : t[65:0];
            hd_step.nq  = {s.nq[30:0], ge};
        end
    endfunction

    logic [12:0] w_w;
    logic [12:0] w_h;
    logic        w_adv;

    logic        r_nd_vld [ND_STEPS+1];
    t_nd         r_nx [ND_STEPS+1];
    t_nd         r_ny [ND_STEPS+1];
    logic [15:0] r_nd_d [ND_STEPS+1];

    logic               r_mu_vld;
    logic signed [62:0] r_prod [4][4];
    logic               r_sum_vld;
    logic signed [65:0] r_hom [4];

    logic        r_hd_vld [HD_STEPS+1];
    t_hd         r_hd [HD_STEPS+1][3];
    logic [65:0] r_hd_dvs [HD_STEPS+1];
    logic [2:0]  r_hd_neg [HD_STEPS+1];
    logic [2:0]  r_hd_ovf [HD_STEPS+1];
    logic        r_hd_deg [HD_STEPS+1];

    logic                  r_ovld;
    logic [OUT_DATA_W-1:0] r_odata;
    logic                  r_odeg;

    logic signed [30:0] w_v [4];
    logic [65:0] w_mh [3];
    logic [65:0] w_md;

    assign w_w   = (i_vp_w == '0) ? 13'd1 : i_vp_w;
    assign w_h   = (i_vp_h == '0) ? 13'd1 : i_vp_h;
    assign w_adv = !r_ovld || i_m_axis_tready;
    assign o_pop = w_adv && i_head.valid;

    always_comb begin
        w_v[0] = $signed({2'b00, r_nx[ND_STEPS].nq}) - 31'sd65536;
        w_v[1] = 31'sd65536 - $signed({2'b00, r_ny[ND_STEPS].nq});
        w_v[2] = $signed({14'b0, r_nd_d[ND_STEPS], 1'b0}) - 31'sd65536;
        w_v[3] = 31'sd65536;
        w_md = r_hom[3][65] ? 66'(-r_hom[3]) : 66'(r_hom[3]);
        for (int l = 0; l < 3; l++) begin
            w_mh[l] = r_hom[l][65] ? 66'(-r_hom[l]) : 66'(r_hom[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= ND_STEPS; s++) begin
                r_nd_vld[s] <= 1'b0;
            end
            for (int s = 0; s <= HD_STEPS; s++) begin
                r_hd_vld[s] <= 1'b0;
            end
            r_mu_vld  <= 1'b0;
            r_sum_vld <= 1'b0;
            r_ovld    <= 1'b0;
        end else if (w_adv) begin
            r_nd_vld[0] <= o_pop;
            for (int s = 1; s <= ND_STEPS; s++) begin
                r_nd_vld[s] <= r_nd_vld[s-1];
            end
            r_mu_vld    <= r_nd_vld[ND_STEPS];
            r_sum_vld   <= r_mu_vld;
            r_hd_vld[0] <= r_sum_vld;
            for (int s = 1; s <= HD_STEPS; s++) begin
                r_hd_vld[s] <= r_hd_vld[s-1];
            end
            r_ovld <= r_hd_vld[HD_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // ndc x and y: floor(p * 2^17 / size), one quotient bit per stage
            r_nx[0].rem <= '0;
            r_nx[0].nq  <= {i_head.item.cursor_x, 17'b0};
            r_ny[0].rem <= '0;
            r_ny[0].nq  <= {i_head.item.cursor_y, 17'b0};
            r_nd_d[0]   <= i_head.item.depth;
            for (int s = 1; s <= ND_STEPS; s++) begin
                r_nx[s]   <= nd_step(r_nx[s-1], w_w);
                r_ny[s]   <= nd_step(r_ny[s-1], w_h);
                r_nd_d[s] <= r_nd_d[s-1];
            end

            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_prod[i][j] <= i_inv[i*4+j] * w_v[j];
                end
            end

            for (int i = 0; i < 4; i++) begin
                r_hom[i] <= r_prod[i][0] + r_prod[i][1] + r_prod[i][2] + r_prod[i][3];
            end

            // perspective divide, 32 quotient bits of |h| * 2^16 / |w|
            for (int l = 0; l < 3; l++) begin
                r_hd[0][l].rem <= 66'(w_mh[l] >> 16);
                r_hd[0][l].nq  <= {w_mh[l][15:0], 16'b0};
                r_hd_ovf[0][l] <= 66'(w_mh[l] >> 16) >= w_md;
                r_hd_neg[0][l] <= r_hom[l][65] ^ r_hom[3][65];
            end
            r_hd_dvs[0] <= w_md;
            r_hd_deg[0] <= r_hom[3] == '0;
            for (int s = 1; s <= HD_STEPS; s++) begin
                for (int l = 0; l < 3; l++) begin
                    r_hd[s][l] <= hd_step(r_hd[s-1][l], r_hd_dvs[s-1]);
                end
                r_hd_dvs[s] <= r_hd_dvs[s-1];
                r_hd_neg[s] <= r_hd_neg[s-1];
                r_hd_ovf[s] <= r_hd_ovf[s-1];
                r_hd_deg[s] <= r_hd_deg[s-1];
            end

            r_odeg <= r_hd_deg[HD_STEPS];
            for (int l = 0; l < 3; l++) begin
                r_odata[32*l +: 32] <= r_hd_deg[HD_STEPS] ? 32'd0 :
                    sat32(r_hd_neg[HD_STEPS][l], r_hd_ovf[HD_STEPS][l],
                          r_hd[HD_STEPS][l].nq);
            end
        end
    end

    assign o_m_axis_tvalid   = r_ovld;
    assign o_m_axis_tdata    = r_odata;
    assign o_m_axis_tuser[0] = r_odeg;

endmodule

>>> src/screen_to_world_unproject_core.sv
// Screen-to-world unprojection. A cursor pixel and a Q0.16 depth enter on the slave stream
// and the world point comes out in signed Q16.16 (saturated) on the master stream, with
// tuser set when the homogeneous w is zero (the point is then zero). Once the inverse
// matrix is ready the block takes one item per clock while the master stream accepts; an
// item passes the 29-step pixel normalization and the 32-step perspective divide pipelines,
// which stall while the master stream holds off. After reset and after every register
// write the inverse of the view-projection matrix is rebuilt by a shared sequencer and
// serial divider, during which s_axis_tready stays low. Write registers only while no
// item is in flight.
module screen_to_world_unproject_core import s2w_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // cursor_x, cursor_y, depth
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,   // world_x, world_y, world_z
    output logic [0:0]            o_m_axis_tuser    // degenerate
);

    logic [VP_W-1:0] r_vp_w;
    logic [VP_W-1:0] r_vp_h;
    t_rows           r_rows;
    logic            w_wr;
    logic            w_known;
    t_inv            w_inv;
    logic            w_inv_valid;
    t_q_head         w_head;
    logic            w_pop;

    assign o_cfg_ready = 1'b1;
    assign w_wr = i_cfg_valid && o_cfg_ready;
    assign w_known = (i_cfg_index == REG_VP_WIDTH) || (i_cfg_index == REG_VP_HEIGHT) ||
                     (i_cfg_index == REG_ROW0) || (i_cfg_index == REG_ROW1) ||
                     (i_cfg_index == REG_ROW2) || (i_cfg_index == REG_ROW3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp_w <= 13'd640;
            r_vp_h <= 13'd480;
            r_rows[0] <= 64'h0000_0000_0000_0100;
            r_rows[1] <= 64'h0000_0000_0100_0000;
            r_rows[2] <= 64'h0000_0100_0000_0000;
            r_rows[3] <= 64'h0100_0000_0000_0000;
        end else if (w_wr) begin
            case (i_cfg_index)
                REG_VP_WIDTH:  r_vp_w <= i_cfg_data[VP_W-1:0];
                REG_VP_HEIGHT: r_vp_h <= i_cfg_data[VP_W-1:0];
                REG_ROW0:      r_rows[0] <= i_cfg_data;
                REG_ROW1:      r_rows[1] <= i_cfg_data;
                REG_ROW2:      r_rows[2] <= i_cfg_data;
                REG_ROW3:      r_rows[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    s2w_inv u_inv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (w_wr && w_known),
        .i_rows    (r_rows),
        .o_inv     (w_inv),
        .o_valid   (w_inv_valid)
    );

    s2w_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_inv_valid     (w_inv_valid),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_pop           (w_pop),
        .o_head          (w_head)
    );

    s2w_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .o_pop           (w_pop),
        .i_vp_w          (r_vp_w),
        .i_vp_h          (r_vp_h),
        .i_inv           (w_inv),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule
